### src/assert_macros.svh
// assertion macros shared by the rtc calendar counter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/rtc_pkg.sv
// types, codes and helper functions for the rtc calendar counter
// no dependencies; imported by every rtc module
package rtc_pkg;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // configuration register indexes
   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CSR_BCD_MODE     = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TWELVE_HOUR  = 1'd1;

   // field limits
   localparam logic [7:0] SEC_MAX     = 8'd59;
   localparam logic [7:0] MIN_MAX     = 8'd59;
   localparam logic [7:0] HOUR_MAX    = 8'd23;
   localparam logic [7:0] WEEKDAY_MAX = 8'd7;
   localparam logic [7:0] DAY_MAX     = 8'd31;
   localparam logic [7:0] MONTH_MAX   = 8'd12;
   localparam logic [7:0] YEAR_MAX    = 8'd99;
   localparam logic [7:0] NOON        = 8'd12;

   typedef struct packed {
      logic bcd_mode;
      logic twelve_hour_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0] second;
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] weekday;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
      logic [7:0] century;
   } raw_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [6:0] century;
   } time_type;

   // in bcd mode low nibble plus ten times high nibble, nibbles above nine kept as is; else b as is
   function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic bcd);
      logic [7:0] hi;
      hi = {4'b0000, b[7:4]};
      if (bcd) begin
         return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
      end
      return b;
   endfunction

   // saturate to the inclusive range lo..hi
   function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] lo,
                                        input logic [7:0] hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

endpackage

### src/rtc_load_decode.sv
// load path: raw clock-chip bytes to a saturated binary calendar time
// depends on rtc_pkg
module rtc_load_decode import rtc_pkg::*; (
   input  raw_type  raw,
   input  cfg_type  cfg,
   output time_type loaded
);

   logic [7:0] hour_byte;
   logic [7:0] hour_dec;
   logic [7:0] hour_24;
   logic       pm;

   // pm flag sits in bit 7 only in twelve-hour mode
   assign pm        = cfg.twelve_hour_mode & raw.hour[7];
   assign hour_byte = cfg.twelve_hour_mode ? {1'b0, raw.hour[6:0]} : raw.hour;
   assign hour_dec  = decode_byte(hour_byte, cfg.bcd_mode);

   // twelve o'clock counts as zero, pm adds twelve
   always_comb begin
      hour_24 = hour_dec;
      if (cfg.twelve_hour_mode) begin
         if (hour_dec == NOON) begin
            hour_24 = 8'd0;
         end
         if (pm) begin
            hour_24 = hour_24 + NOON;
         end
      end
   end

   // decode and saturate every field
   always_comb begin
      logic [7:0] sec_v;
      logic [7:0] min_v;
      logic [7:0] hour_v;
      logic [7:0] wday_v;
      logic [7:0] day_v;
      logic [7:0] mon_v;
      logic [7:0] year_v;
      logic [7:0] cent_v;
      sec_v  = clamp(decode_byte(raw.second, cfg.bcd_mode), 8'd0, SEC_MAX);
      min_v  = clamp(decode_byte(raw.minute, cfg.bcd_mode), 8'd0, MIN_MAX);
      hour_v = clamp(hour_24, 8'd0, HOUR_MAX);
      wday_v = clamp(decode_byte(raw.weekday, cfg.bcd_mode), 8'd1, WEEKDAY_MAX);
      day_v  = clamp(decode_byte(raw.day, cfg.bcd_mode), 8'd1, DAY_MAX);
      mon_v  = clamp(decode_byte(raw.month, cfg.bcd_mode), 8'd1, MONTH_MAX);
      year_v = clamp(decode_byte(raw.year, cfg.bcd_mode), 8'd0, YEAR_MAX);
      cent_v = clamp(decode_byte(raw.century, cfg.bcd_mode), 8'd0, YEAR_MAX);
      loaded.second  = sec_v[5:0];
      loaded.minute  = min_v[5:0];
      loaded.hour    = hour_v[4:0];
      loaded.weekday = wday_v[2:0];
      loaded.day     = day_v[4:0];
      loaded.month   = mon_v[3:0];
      loaded.year    = year_v[6:0];
      loaded.century = cent_v[6:0];
   end

endmodule

### src/rtc_tick_advance.sv
// one-second advance of the calendar cascade, 31-day months
// depends on rtc_pkg
module rtc_tick_advance import rtc_pkg::*; (
   input  time_type cur,
   output time_type nxt
);

   logic sec_wrap;
   logic min_wrap;
   logic hour_wrap;
   logic day_wrap;
   logic month_wrap;
   logic year_wrap;

   // carry conditions along the cascade
   assign sec_wrap   = ({2'b00, cur.second} >= SEC_MAX);
   assign min_wrap   = sec_wrap & ({2'b00, cur.minute} >= MIN_MAX);
   assign hour_wrap  = min_wrap & ({3'b000, cur.hour} >= HOUR_MAX);
   assign day_wrap   = hour_wrap & ({3'b000, cur.day} >= DAY_MAX);
   assign month_wrap = day_wrap & ({4'b0000, cur.month} >= MONTH_MAX);
   assign year_wrap  = month_wrap & ({1'b0, cur.year} >= YEAR_MAX);

   always_comb begin
      nxt = cur;
      nxt.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
      if (sec_wrap) begin
         nxt.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
      end
      if (min_wrap) begin
         nxt.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
      end
      // weekday and day step together at midnight
      if (hour_wrap) begin
         nxt.weekday = ({5'b00000, cur.weekday} >= WEEKDAY_MAX) ? 3'd1 : cur.weekday + 3'd1;
         nxt.day     = day_wrap ? 5'd1 : cur.day + 5'd1;
      end
      if (day_wrap) begin
         nxt.month = month_wrap ? 4'd1 : cur.month + 4'd1;
      end
      if (month_wrap) begin
         nxt.year = year_wrap ? 7'd0 : cur.year + 7'd1;
      end
      if (year_wrap) begin
         nxt.century = ({1'b0, cur.century} >= YEAR_MAX) ? 7'd0 : cur.century + 7'd1;
      end
   end

endmodule

### src/rtc_calendar_time_counter_core.sv
// an accepted word enters the input register, then the time register holds its result word
// throughput: one word per cycle unless stalled; the input and time registers form the pipe
// the time register is also the result register and holds while the result is stalled
// reset: time goes to 00:00:00, weekday 1, day 1, month 1, year 0, century 0,
// bcd decoding on and 24-hour mode
// top level of the rtc calendar counter; depends on rtc_pkg, rtc_load_decode,
// rtc_tick_advance and assert_macros.svh
`include "assert_macros.svh"
module rtc_calendar_time_counter_core import rtc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic                     csr_write_data,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic [7:0]               req_raw_second,
   input  logic [7:0]               req_raw_minute,
   input  logic [7:0]               req_raw_hour,
   input  logic [7:0]               req_raw_weekday,
   input  logic [7:0]               req_raw_day,
   input  logic [7:0]               req_raw_month,
   input  logic [7:0]               req_raw_year,
   input  logic [7:0]               req_raw_century,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [5:0]               rsp_second,
   output logic [5:0]               rsp_minute,
   output logic [4:0]               rsp_hour,
   output logic [2:0]               rsp_weekday,
   output logic [4:0]               rsp_day,
   output logic [3:0]               rsp_month,
   output logic [6:0]               rsp_year,
   output logic [6:0]               rsp_century
);

   cfg_type  cfg_ff, cfg_in;
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_op_ff;
   raw_type  s1_raw_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   time_type time_ff, time_in;
   time_type loaded;
   time_type ticked;
   logic     req_accept;
   logic     advance;
   logic     move;
   logic     time_ok;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BCD_MODE:    cfg_in.bcd_mode = csr_write_data;
            CSR_TWELVE_HOUR: cfg_in.twelve_hour_mode = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bcd_mode         <= 1'b1;
         cfg_ff.twelve_hour_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipe control
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign move        = s1_valid_ff && advance;
   assign req_stall   = s1_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff          <= req_operation;
         s1_raw_ff.second  <= req_raw_second;
         s1_raw_ff.minute  <= req_raw_minute;
         s1_raw_ff.hour    <= req_raw_hour;
         s1_raw_ff.weekday <= req_raw_weekday;
         s1_raw_ff.day     <= req_raw_day;
         s1_raw_ff.month   <= req_raw_month;
         s1_raw_ff.year    <= req_raw_year;
         s1_raw_ff.century <= req_raw_century;
      end
   end

   // next time from either path
   rtc_load_decode u_load (
      .raw    (s1_raw_ff),
      .cfg    (cfg_ff),
      .loaded (loaded)
   );

   rtc_tick_advance u_tick (
      .cur (time_ff),
      .nxt (ticked)
   );

   always_comb begin
      time_in = time_ff;
      if (move) begin
         time_in = (s1_op_ff == OP_LOAD) ? loaded : ticked;
      end
   end

   // calendar time, doubles as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff.second  <= 6'd0;
         time_ff.minute  <= 6'd0;
         time_ff.hour    <= 5'd0;
         time_ff.weekday <= 3'd1;
         time_ff.day     <= 5'd1;
         time_ff.month   <= 4'd1;
         time_ff.year    <= 7'd0;
         time_ff.century <= 7'd0;
      end else begin
         time_ff <= time_in;
      end
   end

   // outputs
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_second  = time_ff.second;
   assign rsp_minute  = time_ff.minute;
   assign rsp_hour    = time_ff.hour;
   assign rsp_weekday = time_ff.weekday;
   assign rsp_day     = time_ff.day;
   assign rsp_month   = time_ff.month;
   assign rsp_year    = time_ff.year;
   assign rsp_century = time_ff.century;

   // every field inside its range
   assign time_ok = (time_ff.second <= 6'd59) && (time_ff.minute <= 6'd59) &&
                    (time_ff.hour <= 5'd23) && (time_ff.weekday != 3'd0) &&
                    (time_ff.day != 5'd0) && (time_ff.month != 4'd0) &&
                    (time_ff.month <= 4'd12) && (time_ff.year <= 7'd99) &&
                    (time_ff.century <= 7'd99);

   // checks
   `ASSERT_ALWAYS(a_time_in_range, clock, reset, time_ok, "calendar time out of range")
   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall,
                   s1_valid_ff && rsp_valid_ff, "request stalled with room in the pipe")
   `ASSERT_NEXT(a_tick_increments_second, clock, reset,
                move && (s1_op_ff == OP_TICK) && (time_ff.second != 6'd59),
                (time_ff.second == $past(time_ff.second) + 6'd1) &&
                (time_ff.minute == $past(time_ff.minute)), "tick did not advance seconds")
   `ASSERT_NEXT(a_time_holds_when_idle, clock, reset, !move, $stable(time_ff),
                "time changed without an item")

endmodule

### sim/rtc_time_checker.sv
// watcher for the rtc calendar counter: tracks csr writes, predicts each result word
// and compares it with what the block returns; depends on rtc_pkg
module rtc_time_checker import rtc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic                     csr_write_data,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_operation,
   input  logic [7:0]               req_raw_second,
   input  logic [7:0]               req_raw_minute,
   input  logic [7:0]               req_raw_hour,
   input  logic [7:0]               req_raw_weekday,
   input  logic [7:0]               req_raw_day,
   input  logic [7:0]               req_raw_month,
   input  logic [7:0]               req_raw_year,
   input  logic [7:0]               req_raw_century,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [5:0]               rsp_second,
   input  logic [5:0]               rsp_minute,
   input  logic [4:0]               rsp_hour,
   input  logic [2:0]               rsp_weekday,
   input  logic [4:0]               rsp_day,
   input  logic [3:0]               rsp_month,
   input  logic [6:0]               rsp_year,
   input  logic [6:0]               rsp_century,
   output int                       errors,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic     bcd_on;
   logic     twelve_on;
   time_type clock_time;
   time_type expected_times[$];
   time_type got;
   time_type want;
   raw_type  raw;
   int       fail_count;

   // raw byte to binary, nibbles above nine weighted as they are
   function automatic logic [7:0] byte_value(input logic [7:0] b, input logic as_bcd);
      if (as_bcd) begin
         return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
      end
      return b;
   endfunction

   function automatic logic [7:0] limit(input logic [7:0] v, input logic [7:0] lo,
                                        input logic [7:0] hi);
      if (v < lo) begin
         return lo;
      end
      return (v > hi) ? hi : v;
   endfunction

   // calendar time after a snapshot load
   function automatic time_type loaded_time(input raw_type r, input logic as_bcd,
                                            input logic twelve);
      time_type   t;
      logic       pm;
      logic [7:0] hr;
      logic [7:0] v;
      pm = twelve & r.hour[7];
      hr = twelve ? {1'b0, r.hour[6:0]} : r.hour;
      hr = byte_value(hr, as_bcd);
      // twelve o'clock counts as zero, afternoon adds twelve
      if (twelve) begin
         if (hr == 8'd12) begin
            hr = 8'd0;
         end
         if (pm) begin
            hr = hr + 8'd12;
         end
      end
      v = limit(byte_value(r.second, as_bcd), 8'd0, 8'd59);
      t.second = v[5:0];
      v = limit(byte_value(r.minute, as_bcd), 8'd0, 8'd59);
      t.minute = v[5:0];
      v = limit(hr, 8'd0, 8'd23);
      t.hour = v[4:0];
      v = limit(byte_value(r.weekday, as_bcd), 8'd1, 8'd7);
      t.weekday = v[2:0];
      v = limit(byte_value(r.day, as_bcd), 8'd1, 8'd31);
      t.day = v[4:0];
      v = limit(byte_value(r.month, as_bcd), 8'd1, 8'd12);
      t.month = v[3:0];
      v = limit(byte_value(r.year, as_bcd), 8'd0, 8'd99);
      t.year = v[6:0];
      v = limit(byte_value(r.century, as_bcd), 8'd0, 8'd99);
      t.century = v[6:0];
      return t;
   endfunction

   // one second later, carrying through the cascade with 31-day months
   function automatic time_type ticked(input time_type t);
      if (t.second != 6'd59) begin
         t.second = t.second + 6'd1;
         return t;
      end
      t.second = 6'd0;
      if (t.minute != 6'd59) begin
         t.minute = t.minute + 6'd1;
         return t;
      end
      t.minute = 6'd0;
      if (t.hour != 5'd23) begin
         t.hour = t.hour + 5'd1;
         return t;
      end
      t.hour = 5'd0;
      t.weekday = (t.weekday == 3'd7) ? 3'd1 : t.weekday + 3'd1;
      if (t.day != 5'd31) begin
         t.day = t.day + 5'd1;
         return t;
      end
      t.day = 5'd1;
      if (t.month != 4'd12) begin
         t.month = t.month + 4'd1;
         return t;
      end
      t.month = 4'd1;
      if (t.year != 7'd99) begin
         t.year = t.year + 7'd1;
         return t;
      end
      t.year = 7'd0;
      t.century = (t.century == 7'd99) ? 7'd0 : t.century + 7'd1;
      return t;
   endfunction

   function automatic string show(input time_type t);
      return $sformatf("%0d:%0d:%0d wd %0d %0d/%0d y %0d c %0d", t.hour, t.minute,
                       t.second, t.weekday, t.day, t.month, t.year, t.century);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         bcd_on = 1'b1;
         twelve_on = 1'b0;
         clock_time = '{second: 6'd0, minute: 6'd0, hour: 5'd0, weekday: 3'd1, day: 5'd1,
                        month: 4'd1, year: 7'd0, century: 7'd0};
         expected_times.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (csr_write_enable) begin
            if (csr_index == CSR_BCD_MODE) begin
               bcd_on = csr_write_data;
            end else if (csr_index == CSR_TWELVE_HOUR) begin
               twelve_on = csr_write_data;
            end
         end

         // result words against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = '{second: rsp_second, minute: rsp_minute, hour: rsp_hour,
                    weekday: rsp_weekday, day: rsp_day, month: rsp_month,
                    year: rsp_year, century: rsp_century};
            if (expected_times.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("rtc_time_checker: unexpected word %s", show(got));
               end
            end else begin
               want = expected_times.pop_front();
               if (got.second !== want.second || got.minute !== want.minute ||
                   got.hour !== want.hour || got.weekday !== want.weekday ||
                   got.day !== want.day || got.month !== want.month ||
                   got.year !== want.year || got.century !== want.century) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("rtc_time_checker: mismatch, expected %s, got %s",
                              show(want), show(got));
                  end
               end
            end
         end

         // accepted request words
         if (req_valid && !req_stall) begin
            raw = {req_raw_second, req_raw_minute, req_raw_hour, req_raw_weekday,
                   req_raw_day, req_raw_month, req_raw_year, req_raw_century};
            if (req_operation == OP_LOAD) begin
               clock_time = loaded_time(raw, bcd_on, twelve_on);
            end else begin
               clock_time = ticked(clock_time);
            end
            expected_times.push_back(clock_time);
         end
      end
      errors  <= fail_count;
      pending <= expected_times.size();
   end

endmodule

### sim/tb.sv
// top of the rtc calendar counter bench: clock, reset, stimulus and verdict
// depends on rtc_pkg, rtc_calendar_time_counter_core and rtc_time_checker
module tb import rtc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD   = 150;
   localparam int CYCLE_LIMIT = 300000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_BCD_MODE;
   logic                     csr_write_data = 1'b0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_operation = OP_TICK;
   logic [7:0]               req_raw_second = 8'd0;
   logic [7:0]               req_raw_minute = 8'd0;
   logic [7:0]               req_raw_hour = 8'd0;
   logic [7:0]               req_raw_weekday = 8'd0;
   logic [7:0]               req_raw_day = 8'd0;
   logic [7:0]               req_raw_month = 8'd0;
   logic [7:0]               req_raw_year = 8'd0;
   logic [7:0]               req_raw_century = 8'd0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [5:0]               rsp_second;
   logic [5:0]               rsp_minute;
   logic [4:0]               rsp_hour;
   logic [2:0]               rsp_weekday;
   logic [4:0]               rsp_day;
   logic [3:0]               rsp_month;
   logic [6:0]               rsp_year;
   logic [6:0]               rsp_century;
   int                       errors;
   int                       pending;

   logic cfg_bcd = 1'b1;
   logic cfg_twelve = 1'b0;
   logic hold_rsp = 1'b0;
   int   burst_left = 0;
   int   cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rtc_calendar_time_counter_core u_top (.*);

   rtc_time_checker u_checker (.*);

   // send one word, opening a new burst after a random gap when the last one ran out
   task automatic send_word(input logic op, input raw_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_raw_second  <= r.second;
      req_raw_minute  <= r.minute;
      req_raw_hour    <= r.hour;
      req_raw_weekday <= r.weekday;
      req_raw_day     <= r.day;
      req_raw_month   <= r.month;
      req_raw_year    <= r.year;
      req_raw_century <= r.century;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // stop sending and wait until every predicted word has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic bcd, input logic twelve);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BCD_MODE;
      csr_write_data   <= bcd;
      @(posedge clock);
      csr_index        <= CSR_TWELVE_HOUR;
      csr_write_data   <= twelve;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_bcd    = bcd;
      cfg_twelve = twelve;
   endtask

   function automatic raw_type random_raw();
      return {$urandom(), $urandom()};
   endfunction

   // value to raw byte in the current encoding
   function automatic logic [7:0] encode(input int v);
      return cfg_bcd ? 8'((v / 10) * 16 + v % 10) : 8'(v);
   endfunction

   // range value biased toward the rollover points
   function automatic int pick(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0: begin
            return hi;
         end
         1: begin
            return hi - 1;
         end
         2: begin
            return lo;
         end
         default: begin
            return $urandom_range(lo, hi);
         end
      endcase
   endfunction

   // well-formed snapshot near a rollover, in the encoding the block expects
   function automatic raw_type sane_raw();
      raw_type r;
      int      h;
      int      h12;
      h = pick(0, 23);
      r = {encode(pick(0, 59)), encode(pick(0, 59)), 8'd0, encode(pick(1, 7)),
           encode(pick(1, 31)), encode(pick(1, 12)), encode(pick(0, 99)),
           encode(pick(0, 99))};
      if (cfg_twelve) begin
         h12 = (h % 12 == 0) ? 12 : h % 12;
         r.hour = encode(h12) | ((h >= 12) ? 8'h80 : 8'h00);
      end else begin
         r.hour = encode(h);
      end
      return r;
   endfunction

   // receiver: stretches of steady flow, light and heavy stalling, and one long hold
   initial begin
      int seg;
      int mode;
      int i;
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(4, 40);
            for (i = 0; i < seg && !hold_rsp; i++) begin
               case (mode)
                  0: begin
                     rsp_stall <= 1'b0;
                  end
                  1: begin
                     rsp_stall <= ($urandom_range(0, 3) == 0);
                  end
                  2: begin
                     rsp_stall <= 1'($urandom_range(0, 1));
                  end
                  default: begin
                     rsp_stall <= ($urandom_range(0, 4) != 0);
                  end
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      int phase;
      int sent;
      int ticks;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bcd, 24-hour: cascade wraps, saturation, non-bcd digits
      send_word(OP_TICK, random_raw());
      send_word(OP_LOAD, 64'h0);
      send_word(OP_LOAD, {8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99, 8'h99});
      send_word(OP_TICK, random_raw());
      send_word(OP_LOAD, {8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99, 8'h98});
      send_word(OP_TICK, random_raw());
      send_word(OP_LOAD, {64{1'b1}});
      send_word(OP_LOAD, {8'h5A, 8'h9F, 8'h24, 8'h08, 8'h32, 8'h13, 8'hA0, 8'h10});
      send_word(OP_TICK, random_raw());
      drain();

      // binary, 12-hour: midnight and noon handling, pm flag on a large hour
      write_config(1'b0, 1'b1);
      send_word(OP_LOAD, {8'd0, 8'd0, 8'h0C, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0});
      send_word(OP_LOAD, {8'd59, 8'd59, 8'h8C, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0});
      send_word(OP_LOAD, {8'd59, 8'd59, 8'h8B, 8'd7, 8'd31, 8'd12, 8'd99, 8'd99});
      send_word(OP_TICK, random_raw());
      send_word(OP_LOAD, {64{1'b1}});
      send_word(OP_LOAD, {8'd30, 8'd30, 8'h00, 8'd0, 8'd0, 8'd0, 8'd50, 8'd20});
      drain();

      // bcd, 12-hour
      write_config(1'b1, 1'b1);
      send_word(OP_LOAD, {8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00});
      send_word(OP_LOAD, {8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00});
      send_word(OP_LOAD, {8'h59, 8'h59, 8'h91, 8'h07, 8'h31, 8'h12, 8'h99, 8'h99});
      send_word(OP_LOAD, {8'h15, 8'h45, 8'h11, 8'h03, 8'h15, 8'h06, 8'h42, 8'h20});
      send_word(OP_LOAD, {8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00});
      drain();

      // binary, 24-hour
      write_config(1'b0, 1'b0);
      send_word(OP_LOAD, {64{1'b1}});
      send_word(OP_LOAD, {8'd59, 8'd59, 8'd23, 8'd7, 8'd31, 8'd12, 8'd99, 8'd99});
      send_word(OP_TICK, random_raw());
      send_word(OP_LOAD, {8'd10, 8'd20, 8'h80, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6});

      // random phases: snapshots near rollovers followed by runs of ticks, plus noise
      for (phase = 0; phase < 5; phase++) begin
         drain();
         write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         // block fills up behind a long receiver hold
         if (phase == 2) begin
            hold_rsp = 1'b1;
         end
         sent = 0;
         while (sent < 100) begin
            if ($urandom_range(0, 3) == 0) begin
               send_word(OP_LOAD, random_raw());
            end else begin
               send_word(OP_LOAD, sane_raw());
            end
            ticks = $urandom_range(0, 6);
            repeat (ticks) send_word(OP_TICK, random_raw());
            sent += 1 + ticks;
         end
      end
      drain();

      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
